// ===== rtl/dcpid_pkg.sv =====
// ----------------------------------------------------------------------------
// dcpid_pkg
// Shared widths, constants, register indexes, state codes and unit status
// type for the DC motor PID drive.
// ----------------------------------------------------------------------------
package dcpid_pkg;

    localparam int POS_W       = 12;
    localparam int ELAPSED_W   = 16;
    localparam int GAIN_W      = 16;
    localparam int ERR_W       = 13;
    localparam int DIFF_W      = 14;
    localparam int PROD_W      = 30;
    localparam int INTEG_W     = 48;
    localparam int ACC_W       = 64;
    localparam int CTRL_W      = 32;
    localparam int DUTY_W      = 8;
    localparam int ZCNT_W      = 5;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int SCALE_W     = 18;
    localparam int NUM_W       = 39;
    localparam int DERIV_QW    = 13;
    localparam int DUTY_QW     = 8;
    localparam int FRAC_BITS   = 8;
    localparam int IN_DATA_W   = 32;
    localparam int OUT_DATA_W  = 48;

    localparam logic [DUTY_W-1:0]  MIN_DUTY   = 8'd50;
    localparam logic [DUTY_W-1:0]  FULL_DUTY  = 8'd255;
    localparam logic [NUM_W-1:0]   DUTY_SPAN  = 39'd205;
    localparam logic [NUM_W-1:0]   DUTY_SATQ  = 39'd206;
    localparam logic [ZCNT_W-1:0]  ZCNT_MAX   = 5'd31;

    localparam logic signed [INTEG_W-1:0] INTEG_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [INTEG_W-1:0] INTEG_MIN = 48'sh8000_0000_0000;
    localparam logic signed [CTRL_W-1:0]  CTRL_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [CTRL_W-1:0]  CTRL_MIN  = 32'sh8000_0000;

    localparam logic [GAIN_W-1:0] KP_RESET     = 16'd2304;
    localparam logic [GAIN_W-1:0] KI_RESET     = 16'd0;
    localparam logic [GAIN_W-1:0] KD_RESET     = 16'd0;
    localparam logic [POS_W-1:0]  TARGET_RESET = 12'd950;
    localparam logic [POS_W-1:0]  BAND_RESET   = 12'd10;
    localparam logic [POS_W-1:0]  LOW_RESET    = 12'd100;
    localparam logic [POS_W-1:0]  HIGH_RESET   = 12'd3000;

    localparam int SETTLE_COUNT_DEF = 20;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_KP         = 3'd0,
        CFG_KI         = 3'd1,
        CFG_KD         = 3'd2,
        CFG_TARGET     = 3'd3,
        CFG_DEAD_BAND  = 3'd4,
        CFG_LOW_LIMIT  = 3'd5,
        CFG_HIGH_LIMIT = 3'd6
    } cfg_index_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_INTEG,
        S_KP,
        S_KI,
        S_KD,
        S_SAT,
        S_BAND,
        S_NUM,
        S_CMP,
        S_DUTY,
        S_OUT
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_status_t;

endpackage

// ===== rtl/dc_motor_pid_drive.sv =====
// ----------------------------------------------------------------------------
// dc_motor_pid_drive
// Position PID controller with deadband, safety window and PWM/direction
// mapping for a DC motor driver, built around a bit-serial multiplier and
// two bit-serial dividers.
//
// Channel   Dir  Handshake                 Payload
// s_axis    in   s_axis_tvalid/tready      tdata: position_sample, elapsed_ms
// m_axis    out  m_axis_tvalid/tready      tdata: control_value, pwm_duty,
//                                          drive_a, drive_b, limit_fault,
//                                          move_done
// cfg       in   cfg_valid/cfg_ready       cfg_index, cfg_data
//
// The block takes one item at a time and is not ready for another until it
// has returned to idle. The multiplier works through the three gains, one gain
// bit a cycle; the duty divider and the glue stages add to this.
// The derivative divider runs alongside the proportional pass.
// After reset the block accepts an item at once. A result that is not taken
// holds the block in its final step until the output register frees up.
// ----------------------------------------------------------------------------
module dc_motor_pid_drive
    import dcpid_pkg::*;
#(
    parameter int SETTLE_COUNT = SETTLE_COUNT_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [11:0] position_sample, [27:12] elapsed_ms, [31:28] zero
    input  logic [IN_DATA_W-1:0]   s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [31:0] control_value, [39:32] pwm_duty, [40] drive_a, [41] drive_b,
    // [42] limit_fault, [43] move_done, [47:44] zero
    output logic [OUT_DATA_W-1:0]  m_axis_tdata,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    state_t state_reg;
    state_t state_next;

    logic [GAIN_W-1:0] kp_reg;
    logic [GAIN_W-1:0] ki_reg;
    logic [GAIN_W-1:0] kd_reg;
    logic [POS_W-1:0]  target_reg;
    logic [POS_W-1:0]  band_reg;
    logic [POS_W-1:0]  low_reg;
    logic [POS_W-1:0]  high_reg;

    logic [POS_W-1:0]            sample_reg;
    logic [ELAPSED_W-1:0]        elapsed_reg;
    logic signed [ERR_W-1:0]     err_reg;
    logic signed [ERR_W-1:0]     last_err_reg;
    logic signed [INTEG_W-1:0]   integ_reg;
    logic signed [INTEG_W-1:0]   integ_next;
    logic signed [PROD_W-1:0]    prod_reg;
    logic                        diff_neg_reg;
    logic signed [CTRL_W-1:0]    u_reg;
    logic signed [CTRL_W-1:0]    u_next;
    logic signed [CTRL_W-1:0]    ctrl_reg;
    logic [CTRL_W-1:0]           mag_reg;
    logic [NUM_W-1:0]            num_reg;
    logic [SCALE_W-1:0]          scale_reg;
    logic [SCALE_W-1:0]          scale_next;
    logic                        sat_reg;
    logic [ZCNT_W-1:0]           zcnt_reg;
    logic [ZCNT_W-1:0]           zcnt_next;
    logic                        m_valid_reg;
    logic [OUT_DATA_W-1:0]       m_data_reg;
    logic [OUT_DATA_W-1:0]       m_data_next;

    logic                        in_accept;
    logic                        mac_start;
    logic                        mac_clear;
    logic [GAIN_W-1:0]           mac_gain;
    logic signed [ACC_W-1:0]     mac_operand;
    logic signed [ACC_W-1:0]     mac_acc;
    unit_status_t                mac_st;
    logic                        deriv_start;
    logic [DERIV_QW-1:0]         deriv_q;
    unit_status_t                deriv_st;
    logic                        duty_start;
    logic [DUTY_QW-1:0]          duty_q;
    unit_status_t                duty_st;
    logic                        out_load;

    logic signed [DIFF_W-1:0]    diff_w;
    logic [DIFF_W-1:0]           diff_abs;
    logic signed [PROD_W-1:0]    prod_w;
    logic signed [INTEG_W:0]     integ_sum;
    logic signed [DIFF_W-1:0]    deriv_w;
    logic [CTRL_W-1:0]           mag_w;
    logic                        in_band;
    logic [SCALE_W+7:0]          kp_scaled;
    logic                        fault;
    logic                        zero_ctrl;
    logic [DUTY_W-1:0]           duty;
    logic                        drive_a;
    logic                        drive_b;
    logic                        move_done;

    assign cfg_ready     = 1'b1;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg     <= KP_RESET;
            ki_reg     <= KI_RESET;
            kd_reg     <= KD_RESET;
            target_reg <= TARGET_RESET;
            band_reg   <= BAND_RESET;
            low_reg    <= LOW_RESET;
            high_reg   <= HIGH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_KP:         kp_reg     <= cfg_data;
                CFG_KI:         ki_reg     <= cfg_data;
                CFG_KD:         kd_reg     <= cfg_data;
                CFG_TARGET:     target_reg <= cfg_data[POS_W-1:0];
                CFG_DEAD_BAND:  band_reg   <= cfg_data[POS_W-1:0];
                CFG_LOW_LIMIT:  low_reg    <= cfg_data[POS_W-1:0];
                CFG_HIGH_LIMIT: high_reg   <= cfg_data[POS_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        s_axis_tready = 1'b0;
        mac_start     = 1'b0;
        mac_clear     = 1'b0;
        mac_gain      = kp_reg;
        mac_operand   = ACC_W'(err_reg);
        deriv_start   = 1'b0;
        duty_start    = 1'b0;
        out_load      = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                state_next = S_INTEG;
            end
            S_INTEG:
            begin
                mac_start   = 1'b1;
                mac_clear   = 1'b1;
                deriv_start = 1'b1;
                state_next  = S_KP;
            end
            S_KP:
            begin
                mac_gain    = ki_reg;
                mac_operand = ACC_W'(integ_reg);
                if (mac_st.done)
                begin
                    mac_start  = 1'b1;
                    state_next = S_KI;
                end
            end
            S_KI:
            begin
                mac_gain    = kd_reg;
                mac_operand = ACC_W'(deriv_w);
                if (mac_st.done)
                begin
                    mac_start  = 1'b1;
                    state_next = S_KD;
                end
            end
            S_KD:
            begin
                if (mac_st.done)
                begin
                    state_next = S_SAT;
                end
            end
            S_SAT:
            begin
                state_next = S_BAND;
            end
            S_BAND:
            begin
                state_next = S_NUM;
            end
            S_NUM:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                duty_start = 1'b1;
                state_next = S_DUTY;
            end
            S_DUTY:
            begin
                if (duty_st.done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign diff_w   = {err_reg[ERR_W-1], err_reg} - {last_err_reg[ERR_W-1], last_err_reg};
    assign diff_abs = diff_w[DIFF_W-1] ? (-diff_w) : diff_w;
    assign prod_w   = err_reg * $signed({1'b0, elapsed_reg});
    assign integ_sum = {integ_reg[INTEG_W-1], integ_reg}
                     + {{(INTEG_W+1-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};

    always_comb
    begin
        integ_next = integ_sum[INTEG_W-1:0];
        if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1])
        begin
            integ_next = integ_sum[INTEG_W] ? INTEG_MIN : INTEG_MAX;
        end
    end

    always_comb
    begin
        deriv_w = $signed({1'b0, deriv_q});
        if (elapsed_reg == '0)
        begin
            deriv_w = '0;
        end
        else if (diff_neg_reg)
        begin
            deriv_w = -$signed({1'b0, deriv_q});
        end
    end

    always_comb
    begin
        u_next = mac_acc[CTRL_W+FRAC_BITS-1:FRAC_BITS];
        if (!((&mac_acc[ACC_W-1:CTRL_W+FRAC_BITS-1]) ||
              !(|mac_acc[ACC_W-1:CTRL_W+FRAC_BITS-1])))
        begin
            u_next = mac_acc[ACC_W-1] ? CTRL_MIN : CTRL_MAX;
        end
    end

    assign mag_w      = u_reg[CTRL_W-1] ? (~u_reg + CTRL_W'(1)) : u_reg;
    assign in_band    = mag_w < CTRL_W'(band_reg);
    assign kp_scaled  = {kp_reg, 10'b0} - (SCALE_W+8)'(kp_reg);
    assign scale_next = kp_scaled[SCALE_W+7:FRAC_BITS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg    <= '0;
            last_err_reg <= '0;
        end
        else if (state_reg == S_INTEG)
        begin
            integ_reg    <= integ_next;
            last_err_reg <= err_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            sample_reg  <= s_axis_tdata[POS_W-1:0];
            elapsed_reg <= s_axis_tdata[POS_W+ELAPSED_W-1:POS_W];
            err_reg     <= $signed({1'b0, target_reg}) - $signed({1'b0, s_axis_tdata[POS_W-1:0]});
        end
        if (state_reg == S_PREP)
        begin
            prod_reg <= prod_w;
        end
        if (state_reg == S_INTEG)
        begin
            diff_neg_reg <= diff_w[DIFF_W-1];
        end
        if (state_reg == S_SAT)
        begin
            u_reg <= u_next;
        end
        if (state_reg == S_BAND)
        begin
            ctrl_reg <= in_band ? '0 : u_reg;
            mag_reg  <= in_band ? '0 : mag_w;
        end
        if (state_reg == S_NUM)
        begin
            num_reg   <= NUM_W'(mag_reg) * DUTY_SPAN;
            scale_reg <= scale_next;
        end
        if (state_reg == S_CMP)
        begin
            sat_reg <= num_reg >= (NUM_W'(scale_reg) * DUTY_SATQ);
        end
    end

    dcpid_serial_mac #(
        .MUL_W (GAIN_W),
        .SUM_W (ACC_W)
    ) u_mac (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (mac_start),
        .clear        (mac_clear),
        .multiplier   (mac_gain),
        .multiplicand (mac_operand),
        .acc          (mac_acc),
        .status       (mac_st)
    );

    dcpid_serial_div #(
        .QW (DERIV_QW),
        .DW (ELAPSED_W)
    ) u_deriv_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (deriv_start),
        .rem_init ('0),
        .dividend (diff_abs[DERIV_QW-1:0]),
        .divisor  (elapsed_reg),
        .quotient (deriv_q),
        .status   (deriv_st)
    );

    dcpid_serial_div #(
        .QW (DUTY_QW),
        .DW (SCALE_W)
    ) u_duty_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (duty_start),
        .rem_init (num_reg[SCALE_W+DUTY_QW-1:DUTY_QW]),
        .dividend (num_reg[DUTY_QW-1:0]),
        .divisor  (scale_reg),
        .quotient (duty_q),
        .status   (duty_st)
    );

    assign fault     = (sample_reg < low_reg) || (sample_reg > high_reg);
    assign zero_ctrl = (ctrl_reg == '0);
    assign duty      = (fault || zero_ctrl || sat_reg) ? FULL_DUTY : (MIN_DUTY + duty_q);
    assign drive_a   = !fault && !zero_ctrl && ctrl_reg[CTRL_W-1];
    assign drive_b   = !fault && !zero_ctrl && !ctrl_reg[CTRL_W-1];
    assign zcnt_next = (zero_ctrl && (zcnt_reg != ZCNT_MAX)) ? (zcnt_reg + ZCNT_W'(1)) : zcnt_reg;
    assign move_done = zcnt_next > ZCNT_W'(SETTLE_COUNT);
    assign m_data_next = {4'b0000, move_done, fault, drive_b, drive_a, duty, ctrl_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zcnt_reg <= '0;
        end
        else if (cfg_valid && cfg_ready && (cfg_index_t'(cfg_index) == CFG_TARGET))
        begin
            zcnt_reg <= '0;
        end
        else if (out_load)
        begin
            zcnt_reg <= zcnt_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_data_reg <= m_data_next;
        end
    end

`ifndef SYNTHESIS
    a_deriv_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_KI && mac_st.done) |-> !deriv_st.busy)
        else $error("derivative quotient not ready when the kd pass starts");

    a_out_from_final: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg == S_OUT))
        else $error("result presented outside the final step");

    a_one_direction: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[40] && m_axis_tdata[41]))
        else $error("both direction lines high");

    a_drive_duty: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tdata[40] || m_axis_tdata[41]))
            |-> (m_axis_tdata[39:32] >= MIN_DUTY))
        else $error("driven output with duty below the minimum");

    a_zero_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && zero_ctrl) |=> (m_axis_tdata[39:32] == FULL_DUTY))
        else $error("zero control value did not stop the motor");
`endif

endmodule

// ===== rtl/dcpid_serial_div.sv =====
// ----------------------------------------------------------------------------
// dcpid_serial_div
// Restoring divider that retires one quotient bit per cycle, starting from a
// preloaded partial remainder that must be below the divisor.
// ----------------------------------------------------------------------------
module dcpid_serial_div
    import dcpid_pkg::*;
#(
    parameter int QW = DUTY_QW,
    parameter int DW = SCALE_W
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] rem_init,
    input  logic [QW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic [QW-1:0] quotient,
    output unit_status_t  status
);

    localparam int CNT_W = (QW > 1) ? $clog2(QW) : 1;
    localparam logic [CNT_W-1:0] LAST = CNT_W'(QW - 1);

    logic [DW-1:0]    rem_reg;
    logic [DW-1:0]    rem_next;
    logic [QW-1:0]    quo_reg;
    logic [QW-1:0]    quo_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             busy_reg;
    logic             busy_next;
    logic [DW+1:0]    trial;
    logic             last;

    assign last  = busy_reg && (cnt_reg == LAST);
    assign trial = {1'b0, rem_reg, quo_reg[QW-1]} - {2'b00, divisor};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rem_next  = rem_init;
            quo_next  = dividend;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial[DW+1])
            begin
                rem_next = {rem_reg[DW-2:0], quo_reg[QW-1]};
                quo_next = {quo_reg[QW-2:0], 1'b0};
            end
            else
            begin
                rem_next = trial[DW-1:0];
                quo_next = {quo_reg[QW-2:0], 1'b1};
            end
            cnt_next  = cnt_reg + CNT_W'(1);
            busy_next = !last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = last;

endmodule

// ===== rtl/dcpid_serial_mac.sv =====
// ----------------------------------------------------------------------------
// dcpid_serial_mac
// Bit-serial multiply-accumulate: an unsigned gain is consumed one bit per
// cycle while a signed multiplicand shifts left into a wide accumulator.
// ----------------------------------------------------------------------------
module dcpid_serial_mac
    import dcpid_pkg::*;
#(
    parameter int MUL_W = GAIN_W,
    parameter int SUM_W = ACC_W
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic                    clear,
    input  logic [MUL_W-1:0]        multiplier,
    input  logic signed [SUM_W-1:0] multiplicand,
    output logic signed [SUM_W-1:0] acc,
    output unit_status_t            status
);

    localparam int CNT_W = (MUL_W > 1) ? $clog2(MUL_W) : 1;
    localparam logic [CNT_W-1:0] LAST = CNT_W'(MUL_W - 1);

    logic signed [SUM_W-1:0] acc_reg;
    logic signed [SUM_W-1:0] acc_next;
    logic signed [SUM_W-1:0] mcand_reg;
    logic signed [SUM_W-1:0] mcand_next;
    logic [MUL_W-1:0]        mplier_reg;
    logic [MUL_W-1:0]        mplier_next;
    logic [CNT_W-1:0]        cnt_reg;
    logic [CNT_W-1:0]        cnt_next;
    logic                    busy_reg;
    logic                    busy_next;
    logic                    last;

    assign last = busy_reg && (cnt_reg == LAST);

    always_comb
    begin
        acc_next    = acc_reg;
        mcand_next  = mcand_reg <<< 1;
        mplier_next = mplier_reg >> 1;
        cnt_next    = cnt_reg;
        busy_next   = busy_reg;
        if (busy_reg)
        begin
            if (mplier_reg[0])
            begin
                acc_next = acc_reg + mcand_reg;
            end
            cnt_next  = cnt_reg + CNT_W'(1);
            busy_next = !last;
        end
        if (start)
        begin
            if (clear)
            begin
                acc_next = '0;
            end
            mcand_next  = multiplicand;
            mplier_next = multiplier;
            cnt_next    = '0;
            busy_next   = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign acc         = acc_reg;
    assign status.busy = busy_reg;
    assign status.done = last;

endmodule
